/* hw/rtl/bsc_pkg.sv */
// Shared types, constants and helper functions for the barometric compensation pipeline.
// Used by bsc_front, bsc_div, bsc_back and baro_sensor_compensation. No dependencies.
package bsc_pkg;

  localparam int RAW_W = 20;
  localparam int TC_W  = 15;
  localparam int PQ_W  = 25;
  localparam int FT_W  = 32;
  localparam int DIV_W = 64;
  localparam int DVS_W = 31;
  localparam int CFG_W = 64;
  localparam int IDX_W = 2;

  localparam int TEMP_MIN_I = -4000;
  localparam int TEMP_MAX_I = 8500;
  localparam logic [PQ_W-1:0] PRESS_MAX = '1;

  localparam logic [IDX_W-1:0] CFG_TEMP  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_PLOW  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_PMID  = 2'd2;
  localparam logic [IDX_W-1:0] CFG_PHIGH = 2'd3;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] plow;
    logic [63:0] pmid;
    logic [15:0] phigh;
  } bsc_cal_t;

  typedef struct packed {
    logic signed [TC_W-1:0] tc;
    logic signed [FT_W-1:0] tfine;
  } bsc_side_t;

  typedef struct packed {
    logic [DIV_W-1:0] quo;
    logic [DVS_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic             neg;
    logic             nz;
    bsc_side_t        side;
  } bsc_div_t;

  // Low 64 bits of a times a sign-extended 16-bit word.
  function automatic logic [63:0] mul64x16s(input logic [63:0] a, input logic [15:0] b);
    logic [63:0] prod;
    logic [63:0] corr;
    prod = a * b;
    corr = b[15] ? (a << 16) : 64'd0;
    return prod - corr;
  endfunction

endpackage

/* hw/rtl/bsc_front.sv */
// Front pipeline: temperature compensation and pressure numerator and divisor (nine stages).
// Depends on bsc_pkg.
module bsc_front import bsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  bsc_cal_t             cal,
  input  logic                 vld_i,
  input  logic [RAW_W-1:0]     raw_t,
  input  logic [RAW_W-1:0]     raw_p,
  output logic                 vld_o,
  output bsc_div_t             div_o
);

  logic [8:0] vld_r;

  logic [15:0]        t1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;
  logic [15:0]        p1;

  assign t1 = cal.temp[15:0];
  assign t2 = cal.temp[31:16];
  assign t3 = cal.temp[47:32];
  assign p1 = cal.plow[15:0];
  assign p2 = cal.plow[31:16];
  assign p3 = cal.plow[47:32];
  assign p4 = cal.plow[63:48];
  assign p5 = cal.pmid[15:0];
  assign p6 = cal.pmid[31:16];

  // Stage 1
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] ma_nxt, mdd_nxt, ma_r, mdd_r;
  logic [20:0]        pr_nxt, pr1_r, pr2_r, pr3_r, pr4_r, pr5_r, pr6_r;

  assign d1      = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2      = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, t1});
  assign ma_nxt  = d1 * t2;
  assign mdd_nxt = d2 * d2;
  assign pr_nxt  = 21'd1048576 - {1'b0, raw_p};

  // Stage 2
  logic signed [22:0] a_r;
  logic signed [37:0] pb_nxt, pb_r;
  assign pb_nxt = $signed(mdd_r[33:12]) * t3;

  // Stage 3
  logic signed [31:0] tf_nxt, tf_r;
  assign tf_nxt = a_r + $signed(pb_r[37:14]);

  // Stage 4
  logic signed [32:0] v1;
  logic signed [65:0] vv_full;
  logic signed [48:0] v1p5_nxt, v1p2_nxt, v1p5_r, v1p2_r, v1p5b_r, v1p2b_r;
  logic signed [34:0] tfx, t5;
  logic signed [26:0] tsh;
  logic signed [TC_W-1:0] tc_nxt;
  logic [63:0] vv_r;
  bsc_side_t side4_r, side5_r, side6_r, side7_r, side8_r;

  assign v1       = tf_r - 33'sd128000;
  assign vv_full  = v1 * v1;
  assign v1p5_nxt = v1 * p5;
  assign v1p2_nxt = v1 * p2;
  assign tfx      = tf_r;
  assign t5       = (tfx <<< 2) + tfx + 35'sd128;
  assign tsh      = t5[34:8];

  always_comb begin
    if (tsh < TEMP_MIN_I) begin
      tc_nxt = TC_W'(TEMP_MIN_I);
    end else if (tsh > TEMP_MAX_I) begin
      tc_nxt = TC_W'(TEMP_MAX_I);
    end else begin
      tc_nxt = tsh[TC_W-1:0];
    end
  end

  // Stage 5
  logic [63:0] x6_r, x3_r;

  // Stage 6
  logic [63:0] e5, e2, v2_nxt, y_nxt, v2_r, y_r;
  assign e5     = {{15{v1p5b_r[48]}}, v1p5b_r};
  assign e2     = {{15{v1p2b_r[48]}}, v1p2b_r};
  assign v2_nxt = x6_r + (e5 << 17) + ({{48{p4[15]}}, p4} << 35);
  assign y_nxt  = {{8{x3_r[63]}}, x3_r[63:8]} + (e2 << 12) + 64'h0000_8000_0000_0000;

  // Stage 7
  logic [63:0] z_r, num0_r;

  // Stage 8
  logic signed [DVS_W-1:0] d_r;
  logic [63:0] num_r;

  // Stage 9
  bsc_div_t div_nxt, div_r;

  always_comb begin
    div_nxt.quo  = num_r[63] ? (64'd0 - num_r) : num_r;
    div_nxt.rem  = '0;
    div_nxt.dvs  = d_r[DVS_W-1] ? DVS_W'(-d_r) : DVS_W'(d_r);
    div_nxt.neg  = num_r[63] ^ d_r[DVS_W-1];
    div_nxt.nz   = (d_r != '0);
    div_nxt.side = side8_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r          <= ma_nxt;
      mdd_r         <= mdd_nxt;
      pr1_r         <= pr_nxt;
      a_r           <= ma_r[33:11];
      pb_r          <= pb_nxt;
      pr2_r         <= pr1_r;
      tf_r          <= tf_nxt;
      pr3_r         <= pr2_r;
      vv_r          <= vv_full[63:0];
      v1p5_r        <= v1p5_nxt;
      v1p2_r        <= v1p2_nxt;
      side4_r.tc    <= tc_nxt;
      side4_r.tfine <= tf_r;
      pr4_r         <= pr3_r;
      x6_r          <= mul64x16s(vv_r, p6);
      x3_r          <= mul64x16s(vv_r, p3);
      v1p5b_r       <= v1p5_r;
      v1p2b_r       <= v1p2_r;
      side5_r       <= side4_r;
      pr5_r         <= pr4_r;
      v2_r          <= v2_nxt;
      y_r           <= y_nxt;
      side6_r       <= side5_r;
      pr6_r         <= pr5_r;
      z_r           <= y_r * p1;
      num0_r        <= {pr6_r, 31'd0} - v2_r;
      side7_r       <= side6_r;
      d_r           <= z_r[63:33];
      num_r         <= num0_r * 12'd3125;
      side8_r       <= side7_r;
      div_r         <= div_nxt;
    end
  end

  assign vld_o = vld_r[8];
  assign div_o = div_r;

endmodule

/* hw/rtl/bsc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, 64 stages.
// Depends on bsc_pkg.
module bsc_div import bsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     vld_i,
  input  bsc_div_t div_i,
  output logic     vld_o,
  output bsc_div_t div_o
);

  function automatic bsc_div_t div_step(input bsc_div_t s);
    bsc_div_t      r;
    logic [DVS_W:0] trial;
    r     = s;
    trial = {s.rem, s.quo[DIV_W-1]};
    if (trial >= {1'b0, s.dvs}) begin
      trial = trial - {1'b0, s.dvs};
      r.quo = {s.quo[DIV_W-2:0], 1'b1};
    end else begin
      r.quo = {s.quo[DIV_W-2:0], 1'b0};
    end
    r.rem = trial[DVS_W-1:0];
    return r;
  endfunction

  bsc_div_t        stg_r [DIV_W];
  logic [DIV_W-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_W-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0] <= div_step(div_i);
      for (int i = 1; i < DIV_W; i++) begin
        stg_r[i] <= div_step(stg_r[i-1]);
      end
    end
  end

  assign vld_o = vld_r[DIV_W-1];
  assign div_o = stg_r[DIV_W-1];

endmodule

/* hw/rtl/bsc_back.sv */
// Back pipeline: quotient sign, pressure correction polynomial and saturation (six stages).
// Depends on bsc_pkg.
module bsc_back import bsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  bsc_cal_t               cal,
  input  logic                   vld_i,
  input  bsc_div_t               div_i,
  output logic                   vld_o,
  output logic signed [TC_W-1:0] tc_o,
  output logic [PQ_W-1:0]        pq_o,
  output logic signed [FT_W-1:0] tfine_o,
  output logic                   pv_o
);

  logic [15:0] p7, p8, p9;
  assign p7 = cal.pmid[47:32];
  assign p8 = cal.pmid[63:48];
  assign p9 = cal.phigh;

  logic [4:0] vld_r;
  bsc_side_t  side1_r, side2_r, side3_r, side4_r, side5_r;
  logic       nz1_r, nz2_r, nz3_r, nz4_r, nz5_r;

  // Stage 1
  logic [63:0] p1_r;

  // Stage 2
  logic [63:0] qq_nxt, qq_r, t9_r, w2p_r, w2pb_r, w2pc_r, p2_r, p3_r, p4_r;
  assign qq_nxt = {{13{p1_r[63]}}, p1_r[63:13]};

  // Stage 3
  logic [63:0] ll_r;
  logic [31:0] c1_r, c2_r;

  // Stage 4
  logic [31:0] csum;
  logic [63:0] u_r;
  assign csum = c1_r + c2_r;

  // Stage 5
  logic [63:0] s_nxt, s_r;
  assign s_nxt = p4_r + {{25{u_r[63]}}, u_r[63:25]} + {{19{w2pc_r[63]}}, w2pc_r[63:19]};

  // Stage 6
  logic [63:0]     rsum;
  logic [PQ_W-1:0] pq_nxt;
  assign rsum = {{8{s_r[63]}}, s_r[63:8]} + ({{48{p7[15]}}, p7} << 4);

  always_comb begin
    if (!nz5_r || rsum[63]) begin
      pq_nxt = '0;
    end else if (rsum[62:PQ_W] != '0) begin
      pq_nxt = PRESS_MAX;
    end else begin
      pq_nxt = rsum[PQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vld_o <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], vld_i};
      vld_o <= vld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= div_i.neg ? (64'd0 - div_i.quo) : div_i.quo;
      side1_r <= div_i.side;
      nz1_r   <= div_i.nz;
      qq_r    <= qq_nxt;
      t9_r    <= mul64x16s(qq_nxt, p9);
      w2p_r   <= mul64x16s(p1_r, p8);
      p2_r    <= p1_r;
      side2_r <= side1_r;
      nz2_r   <= nz1_r;
      ll_r    <= t9_r[31:0] * qq_r[31:0];
      c1_r    <= t9_r[63:32] * qq_r[31:0];
      c2_r    <= t9_r[31:0] * qq_r[63:32];
      w2pb_r  <= w2p_r;
      p3_r    <= p2_r;
      side3_r <= side2_r;
      nz3_r   <= nz2_r;
      u_r     <= ll_r + {csum, 32'd0};
      w2pc_r  <= w2pb_r;
      p4_r    <= p3_r;
      side4_r <= side3_r;
      nz4_r   <= nz3_r;
      s_r     <= s_nxt;
      side5_r <= side4_r;
      nz5_r   <= nz4_r;
      tc_o    <= side5_r.tc;
      tfine_o <= side5_r.tfine;
      pq_o    <= pq_nxt;
      pv_o    <= nz5_r;
    end
  end

endmodule

/* hw/rtl/baro_sensor_compensation.sv */
// Barometric sensor compensation top level: configuration registers and pipeline control.
// Sustains one item per cycle while the output is not stalled.
// The front (9 stages), the one-bit-per-stage divider (64) and the back (6) make up the pipeline.
// The whole pipeline advances when the output register is empty or its result is taken.
// Synchronous active-low reset clears all valid bits and all calibration registers to zero.
// Depends on bsc_pkg, bsc_front, bsc_div and bsc_back.
module baro_sensor_compensation import bsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [RAW_W-1:0]       in_raw_temperature,
  input  logic [RAW_W-1:0]       in_raw_pressure,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [TC_W-1:0] out_temperature_centi,
  output logic [PQ_W-1:0]        out_pressure_q8,
  output logic signed [FT_W-1:0] out_fine_temp,
  output logic                   out_pressure_valid
);

  bsc_cal_t cal_r;
  logic     adv;
  logic     fr_vld, dv_vld;
  bsc_div_t fr_div, dv_div;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TEMP:  cal_r.temp  <= cfg_data[47:0];
        CFG_PLOW:  cal_r.plow  <= cfg_data;
        CFG_PMID:  cal_r.pmid  <= cfg_data;
        CFG_PHIGH: cal_r.phigh <= cfg_data[15:0];
        default:   cal_r       <= cal_r;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  bsc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .cal   (cal_r),
    .vld_i (in_valid),
    .raw_t (in_raw_temperature),
    .raw_p (in_raw_pressure),
    .vld_o (fr_vld),
    .div_o (fr_div)
  );

  bsc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (fr_vld),
    .div_i (fr_div),
    .vld_o (dv_vld),
    .div_o (dv_div)
  );

  bsc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .cal     (cal_r),
    .vld_i   (dv_vld),
    .div_i   (dv_div),
    .vld_o   (out_valid),
    .tc_o    (out_temperature_centi),
    .pq_o    (out_pressure_q8),
    .tfine_o (out_fine_temp),
    .pv_o    (out_pressure_valid)
  );

endmodule

/* dv/baro_sensor_compensation_tb.sv */
// Self-checking testbench for baro_sensor_compensation: drives raw reading pairs under random
// gaps and stalls across several calibration sets and checks every result against a predictor.
// Depends on bsc_pkg and the baro_sensor_compensation RTL.
module baro_sensor_compensation_tb;
  import bsc_pkg::*;

  typedef struct packed {
    logic signed [TC_W-1:0] tc;
    logic [PQ_W-1:0]        pq;
    logic [FT_W-1:0]        ft;
    logic                   pv;
  } reading_t;

  typedef struct {
    int          cal_set;
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    bit          typed;
    reading_t    res;
  } stim_row_t;

  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [RAW_W-1:0] in_raw_temperature;
  logic [RAW_W-1:0] in_raw_pressure;
  logic out_valid;
  logic out_stall;
  logic signed [TC_W-1:0] out_temperature_centi;
  logic [PQ_W-1:0] out_pressure_q8;
  logic signed [FT_W-1:0] out_fine_temp;
  logic out_pressure_valid;

  bsc_cal_t cal;
  reading_t pending_readings[$];
  int errors;
  int cycles;
  bit quiet;

  baro_sensor_compensation i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_raw_temperature(in_raw_temperature),
    .in_raw_pressure(in_raw_pressure),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_temperature_centi(out_temperature_centi),
    .out_pressure_q8(out_pressure_q8),
    .out_fine_temp(out_fine_temp),
    .out_pressure_valid(out_pressure_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] asr64(input logic [63:0] x, input int s);
    logic signed [63:0] sx;
    sx = x;
    return sx >>> s;
  endfunction

  function automatic logic [63:0] sext16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp,
                                          input bsc_cal_t c);
    longint t1, t2, t3, d1, d2, tf, tcl;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, pp, q, w1, w2;
    reading_t r;
    t1 = longint'(c.temp[15:0]);
    t2 = longint'($signed(c.temp[31:16]));
    t3 = longint'($signed(c.temp[47:32]));
    d1 = (longint'(rt) >>> 3) - t1 * 2;
    d2 = (longint'(rt) >>> 4) - t1;
    tf = ((d1 * t2) >>> 11) + ((((d2 * d2) >>> 12) * t3) >>> 14);
    tcl = (tf * 5 + 128) >>> 8;
    if (tcl < TEMP_MIN_I) tcl = TEMP_MIN_I;
    if (tcl > TEMP_MAX_I) tcl = TEMP_MAX_I;
    r.tc = tcl[TC_W-1:0];
    r.ft = tf[31:0];
    p1 = {48'd0, c.plow[15:0]};
    p2 = sext16(c.plow[31:16]);
    p3 = sext16(c.plow[47:32]);
    p4 = sext16(c.plow[63:48]);
    p5 = sext16(c.pmid[15:0]);
    p6 = sext16(c.pmid[31:16]);
    p7 = sext16(c.pmid[47:32]);
    p8 = sext16(c.pmid[63:48]);
    p9 = sext16(c.phigh);
    v1 = 64'(tf) - 64'd128000;
    v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64((64'h0000_8000_0000_0000 + v1) * p1, 33);
    r.pq = '0;
    r.pv = 1'b0;
    if (v1 != 0) begin
      pp = 64'd1048576 - {44'd0, rp};
      pp = div_trunc(((pp << 31) - v2) * 64'd3125, v1);
      q = asr64(pp, 13);
      w1 = asr64(p9 * q * q, 25);
      w2 = asr64(p8 * pp, 19);
      pp = asr64(pp + w1 + w2, 8) + (p7 << 4);
      if (pp[63]) r.pq = '0;
      else if (pp > {39'd0, PRESS_MAX}) r.pq = PRESS_MAX;
      else r.pq = pp[PQ_W-1:0];
      r.pv = 1'b1;
    end
    return r;
  endfunction

  function automatic bsc_cal_t cal_for(input int sel);
    bsc_cal_t c;
    case (sel)
      0: c = '0;
      1: begin
        c.temp = {16'(-1000), 16'(26435), 16'(27504)};
        c.plow = {16'(2855), 16'(3024), 16'(-10685), 16'(36477)};
        c.pmid = {16'(-14600), 16'(15500), 16'(-7), 16'(140)};
        c.phigh = 16'(6000);
      end
      2: c = {48'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF};
      3: c = {48'h8000_8000_0000, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000, 16'h8000};
      4: c = '1;
      5: begin
        c = cal_for(1);
        c.temp[15:0] = c.temp[15:0] + 16'($urandom_range(0, 2000)) - 16'd1000;
        c.plow[15:0] = c.plow[15:0] + 16'($urandom_range(0, 2000)) - 16'd1000;
        c.pmid = c.pmid ^ {$urandom, $urandom} & 64'h00FF_00FF_000F_000F;
        c.phigh = c.phigh + 16'($urandom_range(0, 1000));
      end
      default: c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    endcase
    return c;
  endfunction

  task automatic load_calibration(input bsc_cal_t c);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cal = c;
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TEMP;
    cfg_data <= {16'($urandom_range(0, 65535)), c.temp};
    @(posedge clk);
    cfg_index <= CFG_PLOW;
    cfg_data <= c.plow;
    @(posedge clk);
    cfg_index <= CFG_PMID;
    cfg_data <= c.pmid;
    @(posedge clk);
    cfg_index <= CFG_PHIGH;
    cfg_data <= {$urandom, 16'($urandom), c.phigh};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_reading(input logic [19:0] rt, input logic [19:0] rp, input bit typed,
                              input reading_t res);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_temperature <= rt;
    in_raw_pressure <= rp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_readings.push_back(typed ? res : compensate(rt, rp, cal));
  endtask

  function automatic logic [19:0] rand_raw();
    case ($urandom_range(0, 9))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      default: return 20'($urandom);
    endcase
  endfunction

  // Results that the zero calibration after reset gives for any reading: zero divisor.
  localparam reading_t ZERO_DIV = '{tc: '0, pq: '0, ft: '0, pv: 1'b0};

  stim_row_t directed[] = '{
    '{0, 20'h00000, 20'h00000, 1'b1, ZERO_DIV},
    '{0, 20'hFFFFF, 20'hFFFFF, 1'b1, ZERO_DIV},
    '{0, 20'h00000, 20'hFFFFF, 1'b1, ZERO_DIV},
    '{0, 20'hFFFFF, 20'h00000, 1'b1, ZERO_DIV},
    '{1, 20'h00000, 20'h7FFFF, 1'b0, ZERO_DIV},
    '{1, 20'hFFFFF, 20'h7FFFF, 1'b0, ZERO_DIV},
    '{1, 20'd519888, 20'd415148, 1'b0, ZERO_DIV},
    '{1, 20'd519888, 20'h00000, 1'b0, ZERO_DIV},
    '{1, 20'd519888, 20'hFFFFF, 1'b0, ZERO_DIV},
    '{1, 20'h55555, 20'hAAAAA, 1'b0, ZERO_DIV},
    '{2, 20'h00000, 20'h00000, 1'b0, ZERO_DIV},
    '{2, 20'hFFFFF, 20'hFFFFF, 1'b0, ZERO_DIV},
    '{3, 20'h00000, 20'hFFFFF, 1'b0, ZERO_DIV},
    '{3, 20'hFFFFF, 20'h00000, 1'b0, ZERO_DIV},
    '{4, 20'h00000, 20'h00000, 1'b0, ZERO_DIV},
    '{4, 20'hFFFFF, 20'hFFFFF, 1'b0, ZERO_DIV}
  };

  always @(posedge clk) begin
    reading_t want;
    cycles <= cycles + 1;
    out_stall <= !quiet && $urandom_range(0, 99) < 37;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result tc=%0d pq=%0d ft=%0d pv=%0b", $time,
                 out_temperature_centi, out_pressure_q8, out_fine_temp, out_pressure_valid);
        errors <= errors + 1;
      end else begin
        want = pending_readings.pop_front();
        if (out_temperature_centi !== want.tc || out_pressure_q8 !== want.pq ||
            out_fine_temp !== $signed(want.ft) || out_pressure_valid !== want.pv) begin
          $display("%0t: mismatch expected tc=%0d pq=%0d ft=%0d pv=%0b", $time,
                   want.tc, want.pq, $signed(want.ft), want.pv);
          $display("%0t: mismatch actual   tc=%0d pq=%0d ft=%0d pv=%0b", $time,
                   out_temperature_centi, out_pressure_q8, out_fine_temp, out_pressure_valid);
          errors <= errors + 1;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int cur_set;
    errors = 0;
    cycles = 0;
    quiet = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_TEMP;
    cfg_data = '0;
    in_valid = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    out_stall = 1'b0;
    cal = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_set = 0;
    foreach (directed[i]) begin
      if (directed[i].cal_set != cur_set) begin
        in_valid <= 1'b0;
        cur_set = directed[i].cal_set;
        load_calibration(cal_for(cur_set));
      end
      send_reading(directed[i].raw_t, directed[i].raw_p, directed[i].typed, directed[i].res);
    end

    for (int ph = 0; ph < 7; ph++) begin
      in_valid <= 1'b0;
      load_calibration(cal_for(ph == 0 ? 0 : (ph < 4 ? 5 : 6 + ph)));
      quiet = (ph == 3);
      repeat (90) send_reading(rand_raw(), rand_raw(), 1'b0, ZERO_DIV);
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
